/* sv/stb_pkg.sv */
// Shared types and constants for the software timer bank.
`default_nettype none

package stb_pkg;

  // Default number of timer slots.
  localparam int TIMER_SLOTS_DEF = 16;

  // Most fire events reported for one tick.
  localparam int MAX_RESULTS = 16;

  // Request operation codes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kind codes.
  localparam logic [1:0] KIND_ADDED = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  // One request.
  typedef struct packed {
    logic        op;
    logic [31:0] duration_ms;
    logic        periodic;
    logic [31:0] now_ms;
  } in_t;

  // One result.
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic       last;
  } out_t;

endpackage

`default_nettype wire

/* sv/software_timer_bank_core.sv */
// Top level of the software timer bank: slot table, tick scan and result sequencing.
//
// Usage. A request is taken on a rising edge with start high and busy low.
// An add request claims the lowest free slot and returns one result (timer
// added with its slot, or table full). The slot search visits one valid bit
// a cycle. A tick request, while enabled, walks every slot through the timer
// memory in a two-stage read-modify-write pipeline, one slot a cycle, and
// returns one fire result per expiring timer, up to MAX_RESULTS per tick.
// The last fire result of a tick carries last; a tick with nothing firing
// gives no result. A tick while disabled is taken and dropped.
// Results appear for one cycle on out_item, marked by out_strobe; the
// receiver cannot stall them. The enable register is written through cfg_we
// and cfg_wdata; the user must write it only while the block is idle, and
// the block itself does not enforce this.
// Reset empties the slot table, clears the previous tick time and disables
// the block; the timer memory needs no clearing, as an entry is always
// written on add before it is read.
`default_nettype none

module software_timer_bank_core #(
  parameter int TIMER_SLOTS = stb_pkg::TIMER_SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire stb_pkg::in_t in_item,
  output logic              busy,
  output logic              out_strobe,
  output stb_pkg::out_t     out_item,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata
);

  import stb_pkg::*;

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TIMER_SLOTS - 1);
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  // Low four bits of a slot index, as reported on the result port.
  function automatic logic [3:0] slot4(input logic [SLOT_W-1:0] i);
    logic [SLOT_W+3:0] e;
    e = {4'b0000, i};
    return e[3:0];
  endfunction

  state_t                   state_r;
  logic                     enable_r;
  logic [TIMER_SLOTS-1:0]   valid_r;
  logic [TIMER_SLOTS-1:0]   periodic_r;
  logic [31:0]              prev_tick_r;
  logic [31:0]              elapsed_r;
  logic [31:0]              dur_r;
  logic                     per_r;
  logic [SLOT_W-1:0]        idx_r;
  logic                     p_v_r;
  logic [SLOT_W-1:0]        p_idx_r;
  logic [SLOT_W-1:0]        pend_r;
  logic [CNT_W-1:0]         cnt_r;
  out_t                     out_r;
  logic                     out_strobe_r;

  // Timer memory: target in the upper word, accumulator in the lower word.
  logic [63:0]              mem [TIMER_SLOTS];
  logic [63:0]              rd_data_r;
  logic                     mem_we;
  logic [SLOT_W-1:0]        mem_waddr;
  logic [63:0]              mem_wdata;

  logic [31:0]              tgt;
  logic [31:0]              acc;
  logic [32:0]              sum;
  logic [31:0]              sat;
  logic                     fire;
  logic                     p_act;
  logic [31:0]              acc_nxt;

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  // Second pipeline stage: saturating add of the elapsed time and expiry check.
  always_comb begin
    tgt     = rd_data_r[63:32];
    acc     = rd_data_r[31:0];
    sum     = {1'b0, acc} + {1'b0, elapsed_r};
    sat     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    fire    = (sat >= tgt);
    p_act   = p_v_r && valid_r[p_idx_r];
    acc_nxt = (fire && periodic_r[p_idx_r]) ? 32'd0 : sat;
  end

  // Memory write port: a new timer on add, the updated accumulator on tick.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p_idx_r;
    mem_wdata = {tgt, acc_nxt};
    if (state_r == ST_ADD && !valid_r[idx_r]) begin
      mem_we    = 1'b1;
      mem_waddr = idx_r;
      mem_wdata = {dur_r, 32'd0};
    end else if (p_act) begin
      mem_we = 1'b1;
    end
  end

  // Timer memory with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[idx_r];
  end

  // Control, slot table and result sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      enable_r     <= 1'b0;
      valid_r      <= '0;
      periodic_r   <= '0;
      prev_tick_r  <= 32'd0;
      p_v_r        <= 1'b0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      p_v_r        <= (state_r == ST_SCAN);
      p_idx_r      <= idx_r;

      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end

      unique case (state_r)
        ST_IDLE: begin
          idx_r <= '0;
          if (start) begin
            if (in_item.op == OP_ADD) begin
              dur_r   <= in_item.duration_ms;
              per_r   <= in_item.periodic;
              state_r <= ST_ADD;
            end else if (enable_r) begin
              elapsed_r   <= in_item.now_ms - prev_tick_r;
              prev_tick_r <= in_item.now_ms;
              cnt_r       <= '0;
              state_r     <= ST_SCAN;
            end
          end
        end
        ST_ADD: begin
          if (!valid_r[idx_r]) begin
            valid_r[idx_r]    <= 1'b1;
            periodic_r[idx_r] <= per_r;
            out_strobe_r      <= 1'b1;
            out_r             <= '{kind: KIND_ADDED, slot: slot4(idx_r), last: 1'b1};
            state_r           <= ST_IDLE;
          end else if (idx_r == LAST_IDX) begin
            out_strobe_r <= 1'b1;
            out_r        <= '{kind: KIND_FULL, slot: 4'd0, last: 1'b1};
            state_r      <= ST_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_SCAN: begin
          if (idx_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (cnt_r != '0) begin
            out_strobe_r <= 1'b1;
            out_r        <= '{kind: KIND_FIRED, slot: slot4(pend_r), last: 1'b1};
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // An expiring timer: free a one-shot slot, and hold the event back until the
      // next expiry or the flush, so that the final event of the tick can be marked as last.
      if (p_act && fire) begin
        if (!periodic_r[p_idx_r]) begin
          valid_r[p_idx_r] <= 1'b0;
        end
        if (cnt_r == '0) begin
          pend_r <= p_idx_r;
          cnt_r  <= cnt_r + 1'b1;
        end else if (cnt_r < CNT_MAX) begin
          out_strobe_r <= 1'b1;
          out_r        <= '{kind: KIND_FIRED, slot: slot4(pend_r), last: 1'b0};
          pend_r       <= p_idx_r;
          cnt_r        <= cnt_r + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
